@@ sv/psfp_pkg.sv @@
// Shared types and constants for the particle sensor frame parser.
package psfp_pkg;

  localparam int unsigned CFG_INDEX_W = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_BYTE   = 8'd0,
    CFG_CHECK_ENABLE = 8'd1
  } cfg_reg_t;

  localparam logic [7:0] DEFAULT_START_BYTE = 8'h42;
  localparam logic       DEFAULT_CHECK_EN   = 1'b1;

  // Byte positions inside a 32-byte frame
  localparam logic [4:0] SUM_BYTES      = 5'd30;
  localparam logic [4:0] HEADER_BYTES   = 5'd2;
  localparam logic [4:0] LAST_POSITION  = 5'd31;
  localparam logic [4:0] FIRST_DATA_POS = 5'd1;

  localparam logic [3:0] CHECKSUM_INDEX = 4'd14;

endpackage

@@ sv/particle_sensor_frame_parser.sv @@
// Particle sensor frame parser: hunts for a start byte, assembles frame words, checks the sum.
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid, in_ready, rx_byte                     | in
//   out     | out_valid, out_ready, word_index, word_value,   | out
//           | checksum_ok, last                               |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | in
//
// One byte per cycle while in_ready is high: each byte is parsed in the cycle it is accepted
// and its word, if any, appears in the output register on the next cycle.
// in_ready is high while the output register is empty or being drained.
// A stall on the output holds the word and blocks input; the frame state is not lost.
// rst is synchronous: the parser returns to hunting, the config registers to their defaults.
// cfg_ready is always high; writes take effect on the next byte.
module particle_sensor_frame_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       word_index,
  output logic [15:0]                      word_value,
  output logic                             checksum_ok,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data
);

  logic [7:0]  start_byte;
  logic        check_enable;
  logic        in_frame, in_frame_next;
  logic [4:0]  byte_position, byte_position_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic        out_valid_next;
  logic        emit;
  logic [3:0]  emit_index;
  logic [15:0] emit_word;
  logic        emit_ok, emit_last;
  logic        in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte   <= psfp_pkg::DEFAULT_START_BYTE;
      check_enable <= psfp_pkg::DEFAULT_CHECK_EN;
    end else if (cfg_valid) begin
      case (cfg_index)
        psfp_pkg::CFG_START_BYTE:   start_byte   <= cfg_data;
        psfp_pkg::CFG_CHECK_ENABLE: check_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame_next       = in_frame;
    byte_position_next  = byte_position;
    running_sum_next    = running_sum;
    high_byte_hold_next = high_byte_hold;
    emit                = 1'b0;
    emit_index          = byte_position[4:1] - 4'd1;
    emit_word           = {high_byte_hold, rx_byte};
    emit_ok             = 1'b0;
    emit_last           = 1'b0;
    if (in_accept) begin
      if (!in_frame) begin
        if (rx_byte == start_byte) begin
          in_frame_next       = 1'b1;
          byte_position_next  = psfp_pkg::FIRST_DATA_POS;
          running_sum_next    = {8'd0, rx_byte};
          high_byte_hold_next = 8'd0;
        end
      end else begin
        if (byte_position < psfp_pkg::SUM_BYTES) begin
          running_sum_next = running_sum + {8'd0, rx_byte};
        end
        if (byte_position < psfp_pkg::HEADER_BYTES) begin
          byte_position_next = byte_position + 5'd1;
        end else if (!byte_position[0]) begin
          high_byte_hold_next = rx_byte;
          byte_position_next  = byte_position + 5'd1;
        end else begin
          emit = 1'b1;
          if (byte_position == psfp_pkg::LAST_POSITION) begin
            emit_ok             = !check_enable || (emit_word == running_sum);
            emit_last           = 1'b1;
            in_frame_next       = 1'b0;
            byte_position_next  = 5'd0;
            running_sum_next    = 16'd0;
            high_byte_hold_next = 8'd0;
          end else begin
            byte_position_next = byte_position + 5'd1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (in_accept) begin
      out_valid_next = emit;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      byte_position  <= 5'd0;
      running_sum    <= 16'd0;
      high_byte_hold <= 8'd0;
      out_valid      <= 1'b0;
    end else begin
      in_frame       <= in_frame_next;
      byte_position  <= byte_position_next;
      running_sum    <= running_sum_next;
      high_byte_hold <= high_byte_hold_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      word_index  <= emit_index;
      word_value  <= emit_word;
      checksum_ok <= emit_ok;
      last        <= emit_last;
    end
  end

endmodule

@@ sv/psfp_checker.sv @@
// Port-level checks for the particle sensor frame parser, bound to the top level.
module psfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  word_index,
  input logic [15:0] word_value,
  input logic        checksum_ok,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_value) && $stable(word_index))
    else $error("output transaction changed while stalled");

  a_last_is_checksum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (word_index == psfp_pkg::CHECKSUM_INDEX)))
    else $error("last does not match the checksum word index");

  a_ok_only_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !checksum_ok)
    else $error("checksum flag set on a data word");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .word_index  (word_index),
  .word_value  (word_value),
  .checksum_ok (checksum_ok),
  .last        (last)
);

@@ verif/particle_sensor_frame_parser_test.sv @@
// Self-checking testbench for the particle sensor frame parser, with a byte-level predictor.
module particle_sensor_frame_parser_test;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] val;
    logic        sum_ok;
    logic        is_last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] word_index;
  logic [15:0] word_value;
  logic checksum_ok;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [psfp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = 8'h00;

  logic [7:0] pending_bytes[$];
  frame_word_t expected_words[$];

  // Parser model: configuration and frame state
  logic [7:0]  model_start = psfp_pkg::DEFAULT_START_BYTE;
  logic        model_check = psfp_pkg::DEFAULT_CHECK_EN;
  logic        framing = 1'b0;
  logic [4:0]  position = 5'd0;
  logic [15:0] byte_sum = 16'h0000;
  logic [7:0]  high_hold = 8'h00;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int accepted_bytes = 0;
  int words_checked = 0;
  int frame_ends = 0;
  int bad_sums = 0;
  int queued_bytes = 0;

  particle_sensor_frame_parser DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .word_index  (word_index),
    .word_value  (word_value),
    .checksum_ok (checksum_ok),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    frame_word_t w;
    logic [15:0] assembled;
    if (!framing) begin
      if (b == model_start) begin
        framing = 1'b1;
        position = psfp_pkg::FIRST_DATA_POS;
        byte_sum = {8'h00, b};
        high_hold = 8'h00;
      end
    end else begin
      if (position < psfp_pkg::SUM_BYTES) byte_sum = byte_sum + {8'h00, b};
      if (position < psfp_pkg::HEADER_BYTES) begin
        position = position + 5'd1;
      end else if (!position[0]) begin
        high_hold = b;
        position = position + 5'd1;
      end else begin
        assembled = {high_hold, b};
        w.idx = position[4:1] - 4'd1;
        w.val = assembled;
        if (position == psfp_pkg::LAST_POSITION) begin
          w.sum_ok = !model_check || (assembled == byte_sum);
          w.is_last = 1'b1;
          framing = 1'b0;
          position = 5'd0;
          byte_sum = 16'h0000;
          high_hold = 8'h00;
        end else begin
          w.sum_ok = 1'b0;
          w.is_last = 1'b0;
          position = position + 5'd1;
        end
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic write_reg(input logic [psfp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      psfp_pkg::CFG_START_BYTE:   model_start = data;
      psfp_pkg::CFG_CHECK_ENABLE: model_check = data[0];
      default: ;
    endcase
  endtask

  task automatic queue_frame(input bit good_sum, input bit whole, input bit extremes);
    logic [7:0] fb[32];
    logic [15:0] sum;
    logic [15:0] csum;
    int keep;
    fb[0] = model_start;
    fb[1] = extremes ? model_start : 8'($urandom_range(255));
    if (extremes || $urandom_range(1)) {fb[2], fb[3]} = 16'd28;
    else {fb[2], fb[3]} = 16'($urandom_range(65535));
    for (int i = 4; i < 30; i++) begin
      case ($urandom_range(9))
        0: fb[i] = 8'h00;
        1: fb[i] = 8'hFF;
        2: fb[i] = model_start;
        default: fb[i] = 8'($urandom_range(255));
      endcase
    end
    if (extremes) begin
      {fb[4], fb[5], fb[6], fb[7]} = 32'hFFFF_0000;
      {fb[8], fb[9]} = {model_start, model_start};
    end
    sum = 16'h0000;
    for (int i = 0; i < 30; i++) sum = sum + {8'h00, fb[i]};
    csum = good_sum ? sum : sum ^ 16'($urandom_range(1, 65535));
    {fb[30], fb[31]} = csum;
    keep = whole ? 32 : $urandom_range(1, 31);
    for (int i = 0; i < keep; i++) pending_bytes.push_back(fb[i]);
    queued_bytes += keep;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Driver: present pending bytes, predict on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accepted_bytes++;
        parse_byte(rx_byte);
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transaction with the oldest expected word
  always @(posedge clk) begin
    frame_word_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word index %0d value %h",
                                    word_index, word_value));
        end else begin
          w = expected_words.pop_front();
          words_checked++;
          if (w.is_last) begin
            frame_ends++;
            if (!w.sum_ok) bad_sums++;
          end
          if (word_index !== w.idx)
            report_mismatch($sformatf("word_index %0d, want %0d", word_index, w.idx));
          if (word_value !== w.val)
            report_mismatch($sformatf("word_value %h, want %h (index %0d)",
                                      word_value, w.val, w.idx));
          if (checksum_ok !== w.sum_ok)
            report_mismatch($sformatf("checksum_ok %b, want %b (index %0d)",
                                      checksum_ok, w.sum_ok, w.idx));
          if (last !== w.is_last)
            report_mismatch($sformatf("last %b, want %b (index %0d)",
                                      last, w.is_last, w.idx));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0] noise;
    int phase_start;
    int pick;
    int unsigned raw_index;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hunting drops everything but the start byte; then one frame with extreme words
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(model_start - 8'd1);
    pending_bytes.push_back(model_start + 8'd1);
    queue_frame(1'b1, 1'b1, 1'b1);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      case (phase)
        0: ;
        1: begin
          write_reg(psfp_pkg::CFG_START_BYTE, 8'h00);
          write_reg(psfp_pkg::CFG_CHECK_ENABLE, {7'($urandom_range(127)), 1'b0});
        end
        2: begin
          write_reg(psfp_pkg::CFG_START_BYTE, 8'hFF);
          write_reg(psfp_pkg::CFG_CHECK_ENABLE, {7'($urandom_range(127)), 1'b1});
        end
        3: begin
          write_reg(psfp_pkg::CFG_START_BYTE, 8'($urandom_range(255)));
          raw_index = $urandom_range(2, 255);
          write_reg(raw_index[psfp_pkg::CFG_INDEX_W-1:0], 8'($urandom_range(255)));
        end
        4: begin
          write_reg(psfp_pkg::CFG_START_BYTE, psfp_pkg::DEFAULT_START_BYTE);
          write_reg(psfp_pkg::CFG_CHECK_ENABLE, {7'($urandom_range(127)), 1'b0});
        end
        default: begin
          write_reg(psfp_pkg::CFG_START_BYTE, 8'($urandom_range(255)));
          write_reg(psfp_pkg::CFG_CHECK_ENABLE, 8'($urandom_range(255)));
        end
      endcase

      phase_start = queued_bytes;
      while (queued_bytes - phase_start < 110) begin
        repeat ($urandom_range(3)) begin
          noise = 8'($urandom_range(255));
          if (noise == model_start) noise = noise + 8'd1;
          pending_bytes.push_back(noise);
        end
        pick = $urandom_range(99);
        if (pick < 70) queue_frame(1'b1, 1'b1, 1'b0);
        else if (pick < 88) queue_frame(1'b0, 1'b1, 1'b0);
        else queue_frame(1'($urandom_range(1)), 1'b0, 1'b0);
      end
      drain();
    end

    $display("Summary: %0d bytes accepted, %0d words checked, %0d frames closed (%0d bad sum)",
             accepted_bytes, words_checked, frame_ends, bad_sums);
    $display("         over 8 configuration phases with sender gaps and receiver stalls");
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
